>>> rtl/rfap_pkg.sv
// Shared types, constants and the hex decode helper function of the RFID ASCII frame parser.
`default_nettype none

package rfap_pkg;

   localparam logic [7:0] START_BYTE    = 8'h02;
   localparam logic [7:0] END_BYTE      = 8'h03;
   localparam int         FRAME_DIGITS  = 12;
   localparam logic [3:0] LAST_COUNT    = 4'd12;
   localparam logic [3:0] WAITING_COUNT = 4'd13;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_TAG     = 2'd1,
      EV_ERROR   = 2'd2,
      EV_OVERRUN = 2'd3
   } event_type;

   // Write request from the frame control to the digit store.
   typedef struct packed {
      logic       wr_en;
      logic [3:0] wr_addr;
      logic [3:0] wr_digit;
   } store_wr_type;

   // Decoded view of the twelve stored digits.
   typedef struct packed {
      logic        check_ok;
      logic [15:0] manufacturer;
      logic [23:0] tag_id;
   } store_view_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   // ASCII hex character to digit; a non-hex character gives digit 0.
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r.ok    = 1'b1;
      r.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.value = 4'(c - 8'h57);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/rfap_channels.sv
// Valid/ready channel interfaces for the received byte and the parse result.
`default_nettype none

interface rfap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfap_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_res;
   logic [15:0] manufacturer;
   logic [23:0] tag_id;

   modport source (output valid, output event_res, output manufacturer, output tag_id,
                   input ready);
   modport sink   (input valid, input event_res, input manufacturer, input tag_id,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/rfap_digit_store.sv
// Twelve-entry hex digit store with field extraction and checksum compare.
`default_nettype none

module rfap_digit_store
   import rfap_pkg::*;
(
   input  wire logic         clock,
   input  wire store_wr_type wr,
   output store_view_type    view
);

   logic [3:0] digit_ff [FRAME_DIGITS];
   logic [7:0] sum;

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         digit_ff[wr.wr_addr] <= wr.wr_digit;
      end
   end

   always_comb begin
      sum = 8'd0;
      for (int p = 0; p < 5; p++) begin
         sum = sum ^ {digit_ff[2 * p], digit_ff[2 * p + 1]};
      end
      view.check_ok     = (sum == {digit_ff[10], digit_ff[11]});
      view.manufacturer = {digit_ff[0], digit_ff[1], digit_ff[2], digit_ff[3]};
      view.tag_id       = {digit_ff[4], digit_ff[5], digit_ff[6], digit_ff[7],
                           digit_ff[8], digit_ff[9]};
   end

endmodule

`default_nettype wire

>>> rtl/rfid_ascii_frame_parser.sv
// Top level of the RFID ASCII frame parser: input stage, frame control, result stage.
// A word accepted into the input register moves on to the result register, where its
// result is shown; every accepted word gives exactly one result word.
// Throughput: one word per cycle while the result side does not stall.
// Reset (synchronous, active high) empties both stages and puts the parser in the
// waiting-for-start state; the digit store holds undefined data until it is written.
`default_nettype none

module rfid_ascii_frame_parser
   import rfap_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   rfap_req_if.sink   req_chan,
   rfap_rsp_if.source rsp_chan
);

   // Input stage: holds one received word until the result stage can take it.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Frame state: count of stored characters (13 means waiting for a start
   // byte) and a sticky flag for a non-hex character in the current frame.
   logic [3:0] count_ff, count_in;
   logic       digit_err_ff, digit_err_in;

   // Result stage.
   logic        out_valid_ff, out_valid_in;
   event_type   out_event_ff, out_event_in;
   logic [15:0] out_mfr_ff, out_mfr_in;
   logic [23:0] out_id_ff, out_id_in;

   logic           out_free;
   logic           advance;
   store_wr_type   store_wr;
   store_view_type store_view;
   hex_type        hex;

   // The result stage frees up when empty or when its word is taken, so the
   // input stage can move on in the same cycle and accept a new word.
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   assign in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && !rsp_chan.ready);

   assign hex = hex_decode(in_byte_ff);

   rfap_digit_store u_store (
      .clock (clock),
      .wr    (store_wr),
      .view  (store_view)
   );

   // Frame control. A start byte always restarts the frame. An end byte
   // after exactly twelve characters decodes the frame; it leaves the count
   // at twelve, so a repeated end byte decodes the same frame again. Any
   // other byte is stored while fewer than twelve are held, flags overrun
   // once when twelve are held, and is ignored while waiting.
   always_comb begin
      count_in          = count_ff;
      digit_err_in      = digit_err_ff;
      out_event_in      = out_event_ff;
      out_mfr_in        = out_mfr_ff;
      out_id_in         = out_id_ff;
      store_wr.wr_en    = 1'b0;
      store_wr.wr_addr  = count_ff;
      store_wr.wr_digit = hex.value;
      if (advance) begin
         out_event_in = EV_NONE;
         out_mfr_in   = 16'd0;
         out_id_in    = 24'd0;
         if (in_byte_ff == START_BYTE) begin
            count_in     = 4'd0;
            digit_err_in = 1'b0;
         end else if (in_byte_ff == END_BYTE && count_ff == LAST_COUNT) begin
            if (!digit_err_ff && store_view.check_ok) begin
               out_event_in = EV_TAG;
               out_mfr_in   = store_view.manufacturer;
               out_id_in    = store_view.tag_id;
            end else begin
               out_event_in = EV_ERROR;
            end
         end else if (count_ff < LAST_COUNT) begin
            store_wr.wr_en = 1'b1;
            digit_err_in   = digit_err_ff || !hex.ok;
            count_in       = count_ff + 4'd1;
         end else if (count_ff == LAST_COUNT) begin
            count_in     = WAITING_COUNT;
            out_event_in = EV_OVERRUN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= WAITING_COUNT;
         digit_err_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         digit_err_ff <= digit_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      out_event_ff <= out_event_in;
      out_mfr_ff   <= out_mfr_in;
      out_id_ff    <= out_id_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.event_res    = out_event_ff;
   assign rsp_chan.manufacturer = out_mfr_ff;
   assign rsp_chan.tag_id       = out_id_ff;

endmodule

`default_nettype wire

>>> dv/rfid_ascii_frame_parser_tb.sv
// Self-checking testbench for the RFID ASCII frame parser: frames, noise and random stalls.
`default_nettype none

module rfid_ascii_frame_parser_tb;
   import rfap_pkg::*;

   // The random part stops once about this many frame-shaped words are queued. Raw noise
   // words and the bytes sent after an overrun do not count toward it.
   localparam int RANDOM_WORDS   = 1900;
   // Time given to the parser after the last owed result, before the verdict.
   localparam int DRAIN_CYCLES   = 10;
   // Longest legal quiet time is a send gap plus a receive stall.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // One result word as the parser should present it.
   typedef struct packed {
      event_type   ev;
      logic [15:0] manufacturer;
      logic [23:0] tag_id;
   } parse_result_type;

   logic clock = 1'b0;
   logic reset;

   rfap_req_if req_chan ();
   rfap_rsp_if rsp_chan ();

   rfid_ascii_frame_parser i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Words waiting to be sent, and the results the parser owes us, oldest first.
   logic [7:0]       rx_stream[$];
   parse_result_type pending_results[$];

   // Shadow of the parser's frame state, advanced once per accepted word.
   logic [3:0] frame_count;
   logic [3:0] frame_digits[FRAME_DIGITS];
   logic       frame_bad;

   int  frame_words;
   int  accepted_words;
   int  checked_results;
   int  mismatches;
   int  idle_cycles;
   int  event_tally[4];
   int  send_gap;
   int  stall_left;
   bit  timed_out;
   logic calm_phase;

   parse_result_type want;
   parse_result_type got;

   // Every fourth stretch of 128 accepted words runs with no idling on either side,
   // so the parser also sees back-to-back traffic in both directions.
   assign calm_phase = (accepted_words % 512) >= 384;

   function automatic bit is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   // Only called on characters that passed is_hex; setting bit 5 folds upper case
   // onto lower case.
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      if (c <= 8'h39) return 4'(c - 8'h30);
      return 4'((c | 8'h20) - 8'h57);
   endfunction

   // Advance the shadow state by one received word and return the result it causes.
   function automatic parse_result_type decode_rx_byte(input logic [7:0] c);
      parse_result_type r;
      logic [7:0]       xsum;
      r.ev           = EV_NONE;
      r.manufacturer = '0;
      r.tag_id       = '0;
      if (c == START_BYTE) begin
         frame_count = '0;
         frame_bad   = 1'b0;
      end else if (c == END_BYTE && frame_count == LAST_COUNT) begin
         // The count stays at twelve, so a repeated end byte decodes the same frame.
         xsum = '0;
         for (int p = 0; p < 5; p++) begin
            xsum ^= {frame_digits[2*p], frame_digits[2*p+1]};
         end
         if (!frame_bad && xsum == {frame_digits[10], frame_digits[11]}) begin
            r.ev           = EV_TAG;
            r.manufacturer = {frame_digits[0], frame_digits[1], frame_digits[2],
                              frame_digits[3]};
            r.tag_id       = {frame_digits[4], frame_digits[5], frame_digits[6],
                              frame_digits[7], frame_digits[8], frame_digits[9]};
         end else begin
            r.ev = EV_ERROR;
         end
      end else if (frame_count < LAST_COUNT) begin
         // Anything stored that is not a hex digit, an early end byte included,
         // spoils the frame and is kept as digit zero.
         if (is_hex(c)) begin
            frame_digits[frame_count] = nibble_of(c);
         end else begin
            frame_digits[frame_count] = 4'd0;
            frame_bad = 1'b1;
         end
         frame_count = frame_count + 4'd1;
      end else if (frame_count == LAST_COUNT) begin
         frame_count = WAITING_COUNT;
         r.ev        = EV_OVERRUN;
      end
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 4'd10);
   endfunction

   function automatic logic [7:0] random_non_hex();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (is_hex(c) || c == START_BYTE);
      return c;
   endfunction

   function automatic logic [15:0] pick_manufacturer();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] pick_tag_id();
      case ($urandom_range(0, 9))
         0:       return 24'h000000;
         1:       return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic push_word(input logic [7:0] b, input bit counted);
      rx_stream.push_back(b);
      if (counted) frame_words++;
   endtask

   // Start byte, then n_chars characters of the frame for mfr/id with its check (optionally
   // spoiled, and optionally one character replaced by a bad one), then an optional end byte.
   task automatic push_frame(input logic [15:0] mfr, input logic [23:0] id,
                             input logic [7:0] check_flip, input int n_chars,
                             input int bad_pos, input bit with_end);
      logic [47:0] digits;
      logic [7:0]  check;
      check  = mfr[15:8] ^ mfr[7:0] ^ id[23:16] ^ id[15:8] ^ id[7:0];
      digits = {mfr, id, check ^ check_flip};
      push_word(START_BYTE, 1'b1);
      for (int i = 0; i < n_chars; i++) begin
         push_word((i == bad_pos) ? random_non_hex() : hex_char(digits[47 - 4*i -: 4]), 1'b1);
      end
      if (with_end) push_word(END_BYTE, 1'b1);
   endtask

   task automatic note_mismatch(input string what, input parse_result_type exp_r,
                                input parse_result_type act_r);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("mismatch (%s) at result %0d: expected event %0d mfr %h tag %h,",
                  what, checked_results, exp_r.ev, exp_r.manufacturer, exp_r.tag_id);
         $display("   got event %0d mfr %h tag %h", act_r.ev, act_r.manufacturer,
                  act_r.tag_id);
      end
   endtask

   // Driver: a word stays on the channel until it is taken; after each word a gap
   // of random length may follow before the next one is offered.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.rx_byte <= '0;
         send_gap         <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (send_gap != 0) begin
            req_chan.valid <= 1'b0;
            send_gap       <= send_gap - 1;
         end else if (rx_stream.size() != 0) begin
            req_chan.valid   <= 1'b1;
            req_chan.rx_byte <= rx_stream.pop_front();
            send_gap         <= calm_phase ? 0 : pick_gap();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure: stalls of random length, none in calm stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= 0;
      end else if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= pick_gap();
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Monitor: checks each result word against the oldest expectation, then feeds
   // each accepted input word through the shadow parser. Checking first keeps a
   // result that shows up too early from being matched to the word that caused it.
   // Only an input word or an owed result counts as progress, so a stream of
   // unexpected results cannot keep the run alive.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready && pending_results.size() != 0)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.ev           = event_type'(rsp_chan.event_res);
            got.manufacturer = rsp_chan.manufacturer;
            got.tag_id       = rsp_chan.tag_id;
            if (pending_results.size() == 0) begin
               note_mismatch("no result pending", '0, got);
            end else begin
               want = pending_results.pop_front();
               event_tally[want.ev]++;
               if (got.ev != want.ev) begin
                  note_mismatch("event", want, got);
               end else if (got.manufacturer != want.manufacturer) begin
                  note_mismatch("manufacturer", want, got);
               end else if (got.tag_id != want.tag_id) begin
                  note_mismatch("tag id", want, got);
               end
            end
            checked_results++;
         end
         if (req_chan.valid && req_chan.ready) begin
            pending_results.push_back(decode_rx_byte(req_chan.rx_byte));
            accepted_words++;
         end
      end
   end

   initial begin
      int          pick;
      logic [15:0] mfr;
      logic [23:0] id;
      logic [7:0]  b;

      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      rsp_chan.ready   = 1'b0;
      frame_count      = WAITING_COUNT;
      frame_bad        = 1'b0;
      timed_out        = 1'b0;

      // Directed part. After reset the parser waits for a start byte, so the
      // extremes and a stray end byte are all dropped with no event.
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(END_BYTE, 1'b0);
      // A good frame with an all-ones manufacturer and all-zero tag id.
      push_frame(16'hFFFF, 24'h000000, 8'h00, FRAME_DIGITS, -1, 1'b1);
      // A repeated end byte decodes the same frame again.
      push_word(END_BYTE, 1'b1);
      // A thirteenth character reports overrun once, later bytes are dropped.
      push_word(8'h61, 1'b1);
      push_word(8'h80, 1'b1);
      push_word(END_BYTE, 1'b1);
      // A start byte in mid-frame restarts it; an early end byte is stored as a
      // bad character. The random frames that follow pick the partial frame up.
      push_word(START_BYTE, 1'b1);
      push_word(8'h37, 1'b1);
      push_word(START_BYTE, 1'b1);
      push_word(8'h31, 1'b1);
      push_word(END_BYTE, 1'b1);

      // Random part: well-formed frames with random content in 45 of 100 picks, the rest spoiled
      // checks, bad characters, short, long and cut-off frames, and raw noise.
      frame_words = 0;
      while (frame_words < RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         mfr  = pick_manufacturer();
         id   = pick_tag_id();
         if (pick < 10) begin
            repeat ($urandom_range(1, 4)) push_word(8'($urandom_range(0, 255)), 1'b0);
         end else if (pick < 55) begin
            push_frame(mfr, id, 8'h00, FRAME_DIGITS, -1, 1'b1);
            if ($urandom_range(0, 6) == 0) push_word(END_BYTE, 1'b1);
         end else if (pick < 65) begin
            push_frame(mfr, id, 8'($urandom_range(1, 255)), FRAME_DIGITS, -1, 1'b1);
            if ($urandom_range(0, 6) == 0) push_word(END_BYTE, 1'b1);
         end else if (pick < 75) begin
            push_frame(mfr, id, 8'h00, FRAME_DIGITS, $urandom_range(0, FRAME_DIGITS - 1),
                       1'b1);
         end else if (pick < 83) begin
            push_frame(mfr, id, 8'h00, $urandom_range(0, FRAME_DIGITS - 1), -1, 1'b1);
         end else if (pick < 91) begin
            // Overrun: any thirteenth character but a start or end byte, then a few
            // bytes that the waiting parser drops, possibly a stray end byte.
            push_frame(mfr, id, 8'h00, FRAME_DIGITS, -1, 1'b0);
            do b = 8'($urandom_range(0, 255)); while (b == START_BYTE || b == END_BYTE);
            push_word(b, 1'b1);
            repeat ($urandom_range(0, 3)) begin
               do b = 8'($urandom_range(0, 255)); while (b == START_BYTE);
               push_word(b, 1'b0);
            end
         end else begin
            // Cut off: the next start byte restarts the frame.
            push_frame(mfr, id, 8'h00, $urandom_range(0, FRAME_DIGITS - 1), -1, 1'b0);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      fork
         begin
            do @(negedge clock);
            while (rx_stream.size() != 0 || req_chan.valid || pending_results.size() != 0);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         begin
            while (idle_cycles < WATCHDOG_LIMIT) @(negedge clock);
            timed_out = 1'b1;
         end
      join_any
      disable fork;

      if (timed_out) begin
         $display("no word moved for %0d cycles, %0d results still owed", WATCHDOG_LIMIT,
                  pending_results.size());
      end
      $display("%0d words in, %0d results checked: %0d tags, %0d errors, %0d overruns",
               accepted_words, checked_results, event_tally[EV_TAG], event_tally[EV_ERROR],
               event_tally[EV_OVERRUN]);
      $display("%0d words dropped or mid-frame, %0d mismatches", event_tally[EV_NONE],
               mismatches);
      if (!timed_out && mismatches == 0 && pending_results.size() == 0) begin
         $display("rfid_ascii_frame_parser_tb passed");
      end else begin
         $display("rfid_ascii_frame_parser_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
